// File: hdl/humidity_convert_and_zone_defines.svh
// assertion macros for the humidity block checker
`ifndef HUMIDITY_CONVERT_AND_ZONE_DEFINES_SVH
`define HUMIDITY_CONVERT_AND_ZONE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HCZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define HCZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hcz_pkg.sv
package hcz_pkg;

  localparam int RAW_W      = 16;
  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int HUM_W      = 21;
  localparam int TEMP_W     = 12;
  localparam int ZONE_W     = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USED_W = HUM_W + TEMP_W + ZONE_W + 1;
  localparam int LIMIT_W    = 7;
  localparam int LIM_EXT_W  = LIMIT_W + 2;
  localparam int H_W        = 13;
  localparam int DT_W       = 12;

  localparam int QUEUE_DEPTH = 2;

  // datapath widths
  localparam int SQ_W      = 26;
  localparam int HC_W      = 38;
  localparam int LMUL_W    = 44;
  localparam int LIN_W     = 42;
  localparam int LIN_SPLIT = 21;
  localparam int PLO_W     = 39;
  localparam int PHI_W     = 38;
  localparam int LK_W      = 60;
  localparam int FRAC_W    = 24;
  localparam int FAC_W     = 34;
  localparam int HP_W      = 46;
  localparam int CEIL_W    = HP_W - FRAC_W;

  localparam logic signed [H_W-1:0]    H_OFFSET = 13'sd24;
  localparam logic signed [TEMP_W-1:0] T_OFFSET = 12'sd50;
  localparam logic signed [DT_W-1:0]   T_REF    = 12'sd30;

  // q24 coefficients: c1n is one minus c1, c2n is minus c2
  localparam logic signed [24:0]       COEF_C1N = 25'sd10052908;
  localparam logic signed [17:0]       COEF_C2N = 18'sd65934;
  localparam logic signed [LMUL_W-1:0] COEF_C0  = 44'sd80268912;
  localparam logic signed [16:0]       COEF_K1  = 17'sd39762;
  localparam logic signed [FAC_W-1:0]  COEF_K0  = 34'sd3310145;

  localparam logic signed [HP_W-1:0]  CEIL_BIAS = HP_W'((64'd1 << FRAC_W) - 64'd1);
  localparam logic signed [HUM_W-1:0] HUM_MAX   = {1'b0, {(HUM_W-1){1'b1}}};
  localparam logic signed [HUM_W-1:0] HUM_MIN   = {1'b1, {(HUM_W-1){1'b0}}};
  localparam logic signed [LIM_EXT_W-1:0] HYST  = 9'sd1;

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 7'd85;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 7'd5;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_FAILED = 2'd0,
    ZONE_BELOW  = 2'd1,
    ZONE_WITHIN = 2'd2,
    ZONE_ABOVE  = 2'd3
  } zone_t;

  typedef enum logic {
    CFG_HIGH_LIMIT = 1'b0,
    CFG_LOW_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LINEAR,
    BK_KMUL,
    BK_FACTOR,
    BK_DTMUL,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic signed [H_W-1:0]    h;
    logic signed [TEMP_W-1:0] t;
    logic                     ok;
  } hcz_item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] high;
    logic [LIMIT_W-1:0] low;
  } hcz_limits_t;

endpackage

// File: hdl/humidity_convert_and_zone.sv
// Humidity conversion with safe-range zoning. Each request carries a raw humidity word and a
// raw temperature word in in_tdata and the sensor-ok flag in in_tuser; the block returns the
// compensated humidity (quadratic linearisation plus temperature compensation in q24, ceiling,
// saturated), the coarse temperature, a zone (failed, below, within, above the limits, with one
// step of hysteresis) and a flag set when the zone differs from the previous result. The back
// engine works on one request at a time through its steps (square, linearise, scale, factor,
// temperature product, round and zone) and takes the next only once the result is in the output
// register, waiting in its finish step while a result is still held. A front register and a small queue take
// requests while the engine is busy or a result waits at the output. Limits are to be written on
// the cfg port only while no request is in flight; the block does not enforce this. cfg_ready is always high.
module humidity_convert_and_zone
  import hcz_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // raw_humidity[15:0], raw_temperature[31:16]
  input  logic                  in_tuser,   // sensor_ok
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // humidity[20:0], temperature[32:21],
                                            // zone[34:33], zone_changed[35], zero[39:36]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  hcz_limits_t limits_r;

  logic      push_valid, push_ready;
  hcz_item_t push_item;
  logic      pop_valid, pop_ready;
  hcz_item_t pop_item;

  logic signed [HUM_W-1:0]  humidity;
  logic signed [TEMP_W-1:0] temperature;
  zone_t                    zone;
  logic                     zone_changed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.high <= HIGH_LIMIT_RST;
      limits_r.low  <= LOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HIGH_LIMIT: limits_r.high <= cfg_data;
        CFG_LOW_LIMIT:  limits_r.low  <= cfg_data;
      endcase
    end
  end

  hcz_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hcz_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hcz_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .limits          (limits_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_humidity    (humidity),
    .out_temperature (temperature),
    .out_zone        (zone),
    .out_changed     (zone_changed)
  );

  assign out_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, zone_changed, zone, temperature, humidity};

endmodule

// File: hdl/hcz_queue.sv
module hcz_queue
  import hcz_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  hcz_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output hcz_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcz_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/hcz_front.sv
module hcz_front
  import hcz_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output hcz_item_t            push_item
);

  logic      valid_r;
  hcz_item_t item_r;
  hcz_item_t item_nxt;
  logic      accept;

  assign in_tready  = !valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  // coarse humidity and temperature from the raw words
  always_comb begin
    item_nxt.h  = $signed({1'b0, in_tdata[RAW_W-1:4]}) - H_OFFSET;
    item_nxt.t  = $signed({1'b0, in_tdata[IN_DATA_W-1:RAW_W+5]}) - T_OFFSET;
    item_nxt.ok = in_tuser;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: hdl/hcz_back.sv
module hcz_back
  import hcz_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  hcz_item_t                pop_item,
  input  hcz_limits_t              limits,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [HUM_W-1:0]  out_humidity,
  output logic signed [TEMP_W-1:0] out_temperature,
  output zone_t                    out_zone,
  output logic                     out_changed
);

  back_state_t state_r, state_nxt;

  logic signed [SQ_W-1:0]   hsq_r;
  logic signed [HC_W-1:0]   hc_r;
  logic signed [LIN_W-1:0]  lin_r;
  logic signed [PLO_W-1:0]  plo_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [FAC_W-1:0]  fac_r;
  logic signed [HP_W-1:0]   hp_r;
  logic signed [DT_W-1:0]   dt_r;
  logic signed [TEMP_W-1:0] t_r;
  logic                     ok_r;

  logic signed [LMUL_W-1:0]    lin_full;
  logic signed [LK_W-1:0]      lk;
  logic signed [FAC_W-1:0]     fac_nxt;
  logic signed [HP_W-1:0]      h_sum;
  logic signed [HP_W-1:0]      h_biased;
  logic signed [CEIL_W-1:0]    h_ceil;
  logic [CEIL_W-HUM_W:0]       h_top;
  logic signed [HUM_W-1:0]     hum;
  logic signed [LIM_EXT_W-1:0] hi, lo;
  logic signed [HUM_W-1:0]     hi_ext, lo_ext;
  zone_t                       zone_nxt;
  zone_t                       last_zone_r;

  logic                     out_valid_r;
  logic signed [HUM_W-1:0]  out_hum_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  zone_t                    out_zone_r;
  logic                     out_changed_r;

  logic out_free, load_out, do_pop;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == BK_IDLE);
  assign do_pop    = pop_valid && pop_ready;
  assign load_out  = (state_r == BK_FINISH) && out_free;

  assign out_valid       = out_valid_r;
  assign out_humidity    = out_hum_r;
  assign out_temperature = out_temp_r;
  assign out_zone        = out_zone_r;
  assign out_changed     = out_changed_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (pop_valid) state_nxt = BK_LINEAR;
      BK_LINEAR: state_nxt = BK_KMUL;
      BK_KMUL:   state_nxt = BK_FACTOR;
      BK_FACTOR: state_nxt = BK_DTMUL;
      BK_DTMUL:  state_nxt = BK_FINISH;
      BK_FINISH: if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // linearisation, factor, final sum, ceiling and saturation
  always_comb begin
    lin_full = $signed(hc_r) + hsq_r * COEF_C2N + COEF_C0;
    lk = ($signed({{(LK_W-PHI_W){phi_r[PHI_W-1]}}, phi_r}) <<< LIN_SPLIT)
         + $signed({{(LK_W-PLO_W){plo_r[PLO_W-1]}}, plo_r});
    fac_nxt  = $signed(lk[FRAC_W+FAC_W-1:FRAC_W]) + COEF_K0;
    h_sum    = $signed({{(HP_W-LIN_W){lin_r[LIN_W-1]}}, lin_r}) + hp_r;
    h_biased = h_sum + CEIL_BIAS;
    h_ceil   = h_biased[HP_W-1:FRAC_W];
    h_top    = h_ceil[CEIL_W-1:HUM_W-1];
    if ((&h_top) || !(|h_top)) begin
      hum = h_ceil[HUM_W-1:0];
    end else if (h_ceil[CEIL_W-1]) begin
      hum = HUM_MIN;
    end else begin
      hum = HUM_MAX;
    end
  end

  // zone with one step of hysteresis
  always_comb begin
    hi = $signed({2'b00, limits.high});
    lo = $signed({2'b00, limits.low});
    if (last_zone_r == ZONE_ABOVE || last_zone_r == ZONE_WITHIN) begin
      hi = hi + HYST;
    end
    if (last_zone_r == ZONE_WITHIN || last_zone_r == ZONE_BELOW) begin
      lo = lo - HYST;
    end
    hi_ext = {{(HUM_W-LIM_EXT_W){hi[LIM_EXT_W-1]}}, hi};
    lo_ext = {{(HUM_W-LIM_EXT_W){lo[LIM_EXT_W-1]}}, lo};
    zone_nxt = last_zone_r;
    if (!ok_r) begin
      zone_nxt = ZONE_FAILED;
    end else if (hum > hi_ext) begin
      zone_nxt = ZONE_ABOVE;
    end else if (hum < hi_ext && hum > lo_ext) begin
      zone_nxt = ZONE_WITHIN;
    end else if (hum < lo_ext) begin
      zone_nxt = ZONE_BELOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      last_zone_r <= ZONE_FAILED;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        last_zone_r <= zone_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      hsq_r <= pop_item.h * pop_item.h;
      hc_r  <= pop_item.h * COEF_C1N;
      t_r   <= pop_item.t;
      dt_r  <= pop_item.t - T_REF;
      ok_r  <= pop_item.ok;
    end
    if (state_r == BK_LINEAR) begin
      lin_r <= lin_full[LIN_W-1:0];
    end
    if (state_r == BK_KMUL) begin
      plo_r <= $signed({1'b0, lin_r[LIN_SPLIT-1:0]}) * COEF_K1;
      phi_r <= $signed(lin_r[LIN_W-1:LIN_SPLIT]) * COEF_K1;
    end
    if (state_r == BK_FACTOR) begin
      fac_r <= fac_nxt;
    end
    if (state_r == BK_DTMUL) begin
      hp_r <= dt_r * fac_r;
    end
    if (load_out) begin
      out_hum_r     <= hum;
      out_temp_r    <= t_r;
      out_zone_r    <= zone_nxt;
      out_changed_r <= (zone_nxt != last_zone_r);
    end
  end

endmodule

// File: hdl/hcz_checker.sv
`include "humidity_convert_and_zone_defines.svh"

module hcz_checker
  import hcz_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [7:0]        pending_r;
  logic [ZONE_W-1:0] seen_zone_r;
  logic              in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // requests in flight and last delivered zone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      seen_zone_r <= ZONE_FAILED;
    end else begin
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 1'b1;
      end else if (out_acc && !in_acc) begin
        pending_r <= pending_r - 1'b1;
      end
      if (out_acc) begin
        seen_zone_r <= out_tdata[HUM_W+TEMP_W+ZONE_W-1:HUM_W+TEMP_W];
      end
    end
  end

  `HCZ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `HCZ_ASSERT_NOW(a_no_spurious, out_tvalid, pending_r != 8'd0, "result without a request")
  `HCZ_ASSERT_NOW(a_changed_flag, out_tvalid, out_tdata[35] == (out_tdata[34:33] != seen_zone_r), "zone_changed disagrees with zone history")
  `HCZ_ASSERT_NOW(a_temp_range, out_tvalid, $signed(out_tdata[32:21]) >= -12'sd50 && $signed(out_tdata[32:21]) <= 12'sd1997, "temperature out of range")

endmodule

bind humidity_convert_and_zone hcz_checker u_checker (.*);

// File: tb/humidity_convert_and_zone_test.sv
module humidity_convert_and_zone_test;
  import hcz_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 93;
  localparam int MAX_PRINTS    = 60;

  // packed with humidity in the lowest bits, as on out_tdata
  typedef struct packed {
    logic                     changed;
    zone_t                    zone;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [HUM_W-1:0]  humidity;
  } humidity_result_t;

  typedef enum {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_PULSED
  } ready_mode_t;

  class humidity_scoreboard;
    localparam longint Q24_ONE    = 64'sd16777216;
    localparam longint LIN_C2     = -64'sd65934;
    localparam longint LIN_C1     = 64'sd6724308;
    localparam longint LIN_C0     = 64'sd80268912;
    localparam longint COMP_K1    = 64'sd39762;
    localparam longint COMP_K0    = 64'sd3310145;
    localparam longint HUM_TOP    = 64'sd1048575;
    localparam longint HUM_BOTTOM = -64'sd1048576;

    logic [LIMIT_W-1:0] high_limit = 7'd85;
    logic [LIMIT_W-1:0] low_limit  = 7'd5;
    zone_t              last_zone  = ZONE_FAILED;
    humidity_result_t   expected_q[$];
    int unsigned        errors;
    int unsigned        results_seen;

    // linearised and temperature compensated humidity, ceiling, saturated
    function longint humidity_of(logic [15:0] raw_h, logic [15:0] raw_t);
      longint h, dt, lin, fac, acc, q;
      h   = longint'(raw_h[15:4]) - 24;
      dt  = longint'(raw_t[15:5]) - 80;
      lin = h * Q24_ONE - (LIN_C2 * h * h + LIN_C1 * h - LIN_C0);
      acc = lin * COMP_K1;
      fac = acc / Q24_ONE;
      if (acc % Q24_ONE != 0 && acc < 0) fac = fac - 1;
      fac = fac + COMP_K0;
      acc = lin + dt * fac;
      q   = acc / Q24_ONE;
      if (acc % Q24_ONE != 0 && acc > 0) q = q + 1;
      if (q > HUM_TOP) q = HUM_TOP;
      if (q < HUM_BOTTOM) q = HUM_BOTTOM;
      return q;
    endfunction

    function void write_limit(cfg_reg_t idx, logic [LIMIT_W-1:0] value);
      if (idx == CFG_HIGH_LIMIT) high_limit = value;
      else low_limit = value;
    endfunction

    function void note_request(logic [15:0] raw_h, logic [15:0] raw_t, logic ok);
      longint           hum, hi, lo;
      zone_t            z;
      humidity_result_t r;
      hum = humidity_of(raw_h, raw_t);
      z   = last_zone;
      if (!ok) begin
        z = ZONE_FAILED;
      end else begin
        hi = longint'(high_limit);
        lo = longint'(low_limit);
        if (last_zone == ZONE_WITHIN || last_zone == ZONE_ABOVE) hi = hi + 1;
        if (last_zone == ZONE_WITHIN || last_zone == ZONE_BELOW) lo = lo - 1;
        if (hum > hi) z = ZONE_ABOVE;
        else if (hum < hi && hum > lo) z = ZONE_WITHIN;
        else if (hum < lo) z = ZONE_BELOW;
      end
      r.humidity    = HUM_W'(hum);
      r.temperature = TEMP_W'(longint'(raw_t[15:5]) - 50);
      r.zone        = z;
      r.changed     = (z != last_zone);
      last_zone     = z;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      humidity_result_t got, want;
      got = data[OUT_USED_W-1:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", longint'(data), 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.humidity !== want.humidity)
        report_mismatch("humidity", longint'(got.humidity), longint'(want.humidity));
      if (got.temperature !== want.temperature)
        report_mismatch("temperature", longint'(got.temperature), longint'(want.temperature));
      if (got.zone !== want.zone)
        report_mismatch("zone", longint'(got.zone), longint'(want.zone));
      if (got.changed !== want.changed)
        report_mismatch("zone_changed", longint'(got.changed), longint'(want.changed));
      if (data[OUT_DATA_W-1:OUT_USED_W] !== '0)
        report_mismatch("padding", longint'(data[OUT_DATA_W-1:OUT_USED_W]), 0);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [LIMIT_W-1:0]    cfg_data;

  humidity_scoreboard sb = new();
  int unsigned        burst_left  = 0;
  int unsigned        ready_left  = 0;
  int unsigned        idle_cycles = 0;
  ready_mode_t        ready_mode  = READY_ALWAYS;

  humidity_convert_and_zone dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic [15:0] raw_h, input logic [15:0] raw_t,
                              input logic ok);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_t, raw_h};
    in_tuser  <= ok;
    do @(posedge clk); while (!in_tready);
    sb.note_request(raw_h, raw_t, ok);
  endtask

  // raw words whose humidity lies closest to the target
  function automatic logic [31:0] raw_for_humidity(longint target);
    logic [31:0] best;
    longint      delta, best_delta;
    logic [15:0] raw_h, raw_t;
    best       = '0;
    best_delta = 64'sh7fffffffffffffff;
    for (int hf = 0; hf < 224; hf++) begin
      for (int tf = 60; tf <= 100; tf++) begin
        raw_h = 16'(hf << 4);
        raw_t = 16'(tf << 5);
        delta = sb.humidity_of(raw_h, raw_t) - target;
        if (delta < 0) delta = -delta;
        if (delta < best_delta || (delta == best_delta && $urandom_range(0, 3) == 0)) begin
          best_delta = delta;
          best       = {raw_t, raw_h};
        end
      end
    end
    best[3:0]   = 4'($urandom_range(0, 15));
    best[20:16] = 5'($urandom_range(0, 31));
    return best;
  endfunction

  task automatic send_target(input longint target, input logic ok);
    logic [31:0] raw;
    raw = raw_for_humidity(target);
    send_request(raw[15:0], raw[31:16], ok);
  endtask

  task automatic send_random();
    logic [31:0] raw;
    logic        ok;
    int unsigned kind;
    longint      lim;
    kind = $urandom_range(0, 9);
    ok   = ($urandom_range(0, 11) != 0);
    if (kind == 0) begin
      raw = $urandom;
      ok  = 1'($urandom_range(0, 1));
      send_request(raw[15:0], raw[31:16], ok);
    end else if (kind <= 2) begin
      lim = ($urandom_range(0, 1) == 0) ? longint'(sb.high_limit) : longint'(sb.low_limit);
      send_target(lim + longint'($urandom_range(0, 4)) - 2, ok);
    end else begin
      raw[15:0]  = {12'($urandom_range(0, 140)), 4'($urandom_range(0, 15))};
      raw[31:16] = 16'($urandom_range(1800, 3400));
      send_request(raw[15:0], raw[31:16], ok);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] hi_lim,
                              input logic [LIMIT_W-1:0] lo_lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIGH_LIMIT;
    cfg_data  <= hi_lim;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(CFG_HIGH_LIMIT, hi_lim);
    cfg_index <= CFG_LOW_LIMIT;
    cfg_data  <= lo_lim;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(CFG_LOW_LIMIT, lo_lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] hi_lim,
                           input logic [LIMIT_W-1:0] lo_lim);
    wait_idle();
    write_limits(hi_lim, lo_lim);
    repeat (PHASE_ITEMS) send_random();
  endtask

  // result side: check and stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(8, 60);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_HALF:   out_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:      out_tready <= (ready_left % 12 == 0);
    endcase
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_HIGH_LIMIT;
    cfg_data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // hysteresis walk around the reset limits
    send_request(16'h0000, 16'h0000, 1'b0);
    send_target(50, 1'b1);
    send_target(85, 1'b1);
    send_target(86, 1'b1);
    send_target(87, 1'b1);
    send_target(86, 1'b1);
    send_target(85, 1'b1);
    send_target(5, 1'b1);
    send_target(4, 1'b1);
    send_target(3, 1'b1);
    send_target(4, 1'b1);
    send_target(5, 1'b1);
    send_target(50, 1'b0);
    send_target(85, 1'b1);
    // extremes of the raw words
    send_request(16'h0000, 16'h0000, 1'b1);
    send_request(16'hffff, 16'hffff, 1'b1);
    send_request(16'hffff, 16'h0000, 1'b1);
    send_request(16'h0000, 16'hffff, 1'b1);
    send_request(16'hffff, 16'hffff, 1'b0);
    repeat (PHASE_ITEMS) send_random();

    run_phase(7'd127, 7'd0);
    run_phase(7'd0, 7'd127);
    run_phase(7'd0, 7'd0);
    run_phase(7'd127, 7'd127);
    run_phase(7'd100, 7'd0);
    run_phase(7'd60, 7'd40);
    run_phase(7'd50, 7'd50);
    run_phase(7'($urandom_range(40, 110)), 7'($urandom_range(0, 40)));
    run_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));

    wait_idle();
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
